### hdl/sorted_multi_timer_pool_assert.svh
// Assertion macros for the sorted timer pool.
`ifndef SORTED_MULTI_TIMER_POOL_ASSERT_SVH
`define SORTED_MULTI_TIMER_POOL_ASSERT_SVH

`ifndef SYNTHESIS
`define SMTP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define SMTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SMTP_ASSERT_ALWAYS(lbl, expr, msg)
`define SMTP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### hdl/smtp_pkg.sv
// Types and constants shared by the sorted timer pool.
`timescale 1ns / 1ps
package smtp_pkg;

  localparam int TIMER_COUNT_DEF = 32;
  localparam int MAX_RESULTS = 32;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_ALLOC = 3'd1;
  localparam logic [2:0] ACT_FREE = 3'd2;
  localparam logic [2:0] ACT_BIND = 3'd3;
  localparam logic [2:0] ACT_ARM = 3'd4;
  localparam logic [2:0] ACT_CANCEL = 3'd5;
  localparam logic [2:0] ACT_CANCEL_ALL = 3'd6;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_SWITCH = 2'd2;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN = 2'd2;

  typedef struct packed {
    logic [3:0]         queue;
    logic signed [31:0] payload;
    logic [31:0]        deadline;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_TK_RD, S_TK_CHK, S_TK_FLUSH,
    S_AL_SCAN,
    S_CA_RD, S_CA_CHK, S_CA_FREE,
    S_UL_START, S_UL_HNX, S_UL_HDL, S_UL_WCHK, S_UL_WFIX,
    S_ARM_RD, S_ARM_WR,
    S_IN_START, S_IN_CHK, S_IN_NX, S_IN_FIX,
    S_BD_RD, S_BD_WR,
    S_FREE_DONE, S_ACK
  } state_e;

endpackage

### hdl/smtp_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module smtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sorted_multi_timer_pool.sv
// Top level of the sorted timer pool: sequencer, entry state and result register.
`timescale 1ns / 1ps
// Timer pool whose running timers form a deadline-sorted linked list ending in a
// sentinel entry 0. One input beat is handled at a time. Entry data and links sit in
// RAMs with registered read, so a list step takes a read state and a check state where
// the entry data must be read, and a single state where only links are followed.
// Unlinking a timer at the head reads its link and then the new head's deadline;
// elsewhere the walk follows links from the head to the entry ahead of it. Arm does
// the unlink, then reads each entry's deadline from the head to find the insertion
// point. A tick with nothing due goes straight to its result; otherwise it walks
// the expired timers from the head; any task switch beat comes last. Allocate scans
// for a free entry; cancel-all scans the entries and unlinks each removed running
// timer. The result register lets the next input beat in while the final result waits.
module sorted_multi_timer_pool #(
  parameter int TIMER_COUNT = smtp_pkg::TIMER_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  input  logic [4:0]          timer_index_i,
  input  logic [31:0]         delay_i,
  input  logic signed [31:0]  payload_i,
  input  logic [3:0]          queue_id_i,
  input  logic                auto_cancel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [3:0]          out_queue_o,
  output logic signed [31:0]  out_payload_o,
  output logic [4:0]          out_index_o,
  output logic                success_o,
  output logic                last_o
);

  import smtp_pkg::*;
  `include "sorted_multi_timer_pool_assert.svh"

  localparam int IW = $clog2(TIMER_COUNT);
  localparam int HW = (IW > 5) ? IW : 5;
  localparam logic [IW:0] TC1 = (IW+1)'(TIMER_COUNT);
  localparam logic [5:0] RES_LIMIT = 6'(MAX_RESULTS - 1);

  state_e state_q, state_d, ret_q, ret_d;
  logic [2:0] act_q, act_d;
  logic [IW-1:0] cur_q, cur_d, p_q, p_d, s_q, s_d, head_q, head_d;
  logic vld_q, vld_d, first_q, first_d;
  logic [31:0] delay_q, delay_d, dd_q, dd_d, earliest_q, earliest_d, tick_q, tick_d;
  logic signed [31:0] pay_q, pay_d, pend_pay_q, pend_pay_d;
  logic [3:0] qid_q, qid_d, pend_queue_q, pend_queue_d;
  logic acin_q, acin_d;
  logic [IW:0] scan_q, scan_d;
  logic [4:0] task_q, task_d, oidx_q, oidx_d;
  logic [1:0] status_q [TIMER_COUNT];
  logic [1:0] status_d [TIMER_COUNT];
  logic acf_q [TIMER_COUNT];
  logic acf_d [TIMER_COUNT];
  logic [5:0] cnt_q, cnt_d;
  logic ts_q, ts_d, pend_v_q, pend_v_d, succ_q, succ_d;

  logic out_valid_q, out_valid_d, out_succ_q, out_succ_d, out_last_q, out_last_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [3:0] out_queue_q, out_queue_d;
  logic signed [31:0] out_pay_q, out_pay_d;
  logic [4:0] out_idx_q, out_idx_d;

  logic a_we, a_re, b_we, b_re;
  logic [IW-1:0] a_waddr, a_raddr, b_waddr, b_raddr, b_wdata, b_rdata;
  entry_t a_wdata, a_rdata;

  logic can_emit, is_task;
  logic [IW-1:0] b_next, nxt_p;
  logic [31:0] dl_p, tick_nx;
  logic [1:0] st_cur;

  smtp_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_COUNT)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  smtp_ram #(.WIDTH(IW), .DEPTH(TIMER_COUNT)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign can_emit = !out_valid_q || out_ready_i;
  assign b_next = ({1'b0, b_rdata} < TC1) ? b_rdata : '0;
  assign nxt_p = (p_q == '0) ? '0 : b_next;
  assign dl_p = (p_q == '0) ? ALL_ONES : a_rdata.deadline;
  assign is_task = (HW'(p_q) == HW'(task_q));
  assign tick_nx = tick_q + 32'd1;
  assign st_cur = status_q[cur_q];

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    act_d = act_q;
    cur_d = cur_q;
    p_d = p_q;
    s_d = s_q;
    head_d = head_q;
    vld_d = vld_q;
    first_d = first_q;
    delay_d = delay_q;
    dd_d = dd_q;
    earliest_d = earliest_q;
    tick_d = tick_q;
    pay_d = pay_q;
    pend_pay_d = pend_pay_q;
    qid_d = qid_q;
    pend_queue_d = pend_queue_q;
    acin_d = acin_q;
    scan_d = scan_q;
    task_d = task_q;
    oidx_d = oidx_q;
    status_d = status_q;
    acf_d = acf_q;
    cnt_d = cnt_q;
    ts_d = ts_q;
    pend_v_d = pend_v_q;
    succ_d = succ_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d = out_kind_q;
    out_queue_d = out_queue_q;
    out_pay_d = out_pay_q;
    out_idx_d = out_idx_q;
    out_succ_d = out_succ_q;
    out_last_d = out_last_q;
    a_we = 1'b0;
    a_waddr = cur_q;
    a_wdata = a_rdata;
    a_re = 1'b0;
    a_raddr = cur_q;
    b_we = 1'b0;
    b_waddr = cur_q;
    b_wdata = p_q;
    b_re = 1'b0;
    b_raddr = cur_q;

    if (cfg_valid_i) begin
      task_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = action_i;
          cur_d = IW'(timer_index_i);
          vld_d = (timer_index_i != 5'd0) && (int'(timer_index_i) < TIMER_COUNT);
          delay_d = delay_i;
          pay_d = payload_i;
          qid_d = queue_id_i;
          acin_d = auto_cancel_i;
          succ_d = 1'b0;
          oidx_d = '0;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        dd_d = delay_q + tick_q;
        case (act_q)
          ACT_TICK: begin
            tick_d = tick_nx;
            cnt_d = '0;
            ts_d = 1'b0;
            pend_v_d = 1'b0;
            p_d = head_q;
            state_d = (earliest_q <= tick_nx) ? S_TK_RD : S_TK_FLUSH;
          end
          ACT_ALLOC: begin
            scan_d = '0;
            state_d = S_AL_SCAN;
          end
          ACT_FREE: begin
            if (vld_q && st_cur == ST_RUN) begin
              ret_d = S_FREE_DONE;
              state_d = S_UL_START;
            end else if (vld_q) begin
              state_d = S_FREE_DONE;
            end else begin
              state_d = S_ACK;
            end
          end
          ACT_BIND: begin
            state_d = vld_q ? S_BD_RD : S_ACK;
          end
          ACT_ARM: begin
            if (vld_q && st_cur == ST_RUN) begin
              ret_d = S_ARM_RD;
              state_d = S_UL_START;
            end else if (vld_q && st_cur != ST_FREE) begin
              state_d = S_ARM_RD;
            end else begin
              state_d = S_ACK;
            end
          end
          ACT_CANCEL: begin
            if (vld_q && st_cur == ST_RUN) begin
              succ_d = 1'b1;
              ret_d = S_ACK;
              state_d = S_UL_START;
            end else begin
              state_d = S_ACK;
            end
          end
          ACT_CANCEL_ALL: begin
            scan_d = (IW+1)'(1);
            state_d = S_CA_RD;
          end
          default: begin
            state_d = S_ACK;
          end
        endcase
      end
      S_TK_RD: begin
        a_re = 1'b1;
        a_raddr = p_q;
        b_re = 1'b1;
        b_raddr = p_q;
        state_d = S_TK_CHK;
      end
      S_TK_CHK: begin
        if (p_q == '0 || dl_p > tick_q || (!is_task && cnt_q >= RES_LIMIT)) begin
          head_d = p_q;
          earliest_d = dl_p;
          state_d = S_TK_FLUSH;
        end else if (is_task) begin
          status_d[p_q] = ST_ALLOC;
          ts_d = 1'b1;
          p_d = nxt_p;
          state_d = S_TK_RD;
        end else if (!pend_v_q || can_emit) begin
          if (pend_v_q) begin
            out_valid_d = 1'b1;
            out_kind_d = KIND_EXPIRY;
            out_queue_d = pend_queue_q;
            out_pay_d = pend_pay_q;
            out_idx_d = '0;
            out_succ_d = 1'b0;
            out_last_d = 1'b0;
          end
          status_d[p_q] = ST_ALLOC;
          pend_v_d = 1'b1;
          pend_queue_d = a_rdata.queue;
          pend_pay_d = a_rdata.payload;
          cnt_d = cnt_q + 6'd1;
          p_d = nxt_p;
          state_d = S_TK_RD;
        end
      end
      S_TK_FLUSH: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_queue_d = '0;
          out_pay_d = '0;
          out_idx_d = '0;
          out_succ_d = 1'b0;
          out_last_d = 1'b1;
          if (pend_v_q) begin
            out_kind_d = KIND_EXPIRY;
            out_queue_d = pend_queue_q;
            out_pay_d = pend_pay_q;
            out_last_d = !ts_q;
            pend_v_d = 1'b0;
            if (!ts_q) begin
              state_d = S_IDLE;
            end
          end else if (ts_q) begin
            out_kind_d = KIND_SWITCH;
            state_d = S_IDLE;
          end else begin
            out_kind_d = KIND_NONE;
            state_d = S_IDLE;
          end
        end
      end
      S_AL_SCAN: begin
        if (scan_q == TC1) begin
          state_d = S_ACK;
        end else if (status_q[scan_q[IW-1:0]] == ST_FREE) begin
          status_d[scan_q[IW-1:0]] = ST_ALLOC;
          acf_d[scan_q[IW-1:0]] = 1'b0;
          oidx_d = 5'(scan_q);
          succ_d = 1'b1;
          state_d = S_ACK;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_CA_RD: begin
        if (scan_q == TC1) begin
          state_d = S_ACK;
        end else begin
          a_re = 1'b1;
          a_raddr = scan_q[IW-1:0];
          cur_d = scan_q[IW-1:0];
          state_d = S_CA_CHK;
        end
      end
      S_CA_CHK: begin
        if (st_cur != ST_FREE && acf_q[cur_q] && a_rdata.queue == qid_q) begin
          if (st_cur == ST_RUN) begin
            ret_d = S_CA_FREE;
            state_d = S_UL_START;
          end else begin
            status_d[cur_q] = ST_FREE;
            scan_d = scan_q + 1'b1;
            state_d = S_CA_RD;
          end
        end else begin
          scan_d = scan_q + 1'b1;
          state_d = S_CA_RD;
        end
      end
      S_CA_FREE: begin
        status_d[cur_q] = ST_FREE;
        scan_d = scan_q + 1'b1;
        state_d = S_CA_RD;
      end
      S_UL_START: begin
        b_re = 1'b1;
        if (head_q == cur_q) begin
          b_raddr = cur_q;
          state_d = S_UL_HNX;
        end else begin
          p_d = head_q;
          b_raddr = head_q;
          state_d = S_UL_WCHK;
        end
      end
      S_UL_HNX: begin
        head_d = b_next;
        if (b_next == '0) begin
          earliest_d = ALL_ONES;
          status_d[cur_q] = ST_ALLOC;
          state_d = ret_q;
        end else begin
          a_re = 1'b1;
          a_raddr = b_next;
          state_d = S_UL_HDL;
        end
      end
      S_UL_HDL: begin
        earliest_d = a_rdata.deadline;
        status_d[cur_q] = ST_ALLOC;
        state_d = ret_q;
      end
      S_UL_WCHK: begin
        if (nxt_p == cur_q) begin
          b_re = 1'b1;
          b_raddr = cur_q;
          state_d = S_UL_WFIX;
        end else if (p_q == '0) begin
          status_d[cur_q] = ST_ALLOC;
          state_d = ret_q;
        end else begin
          p_d = nxt_p;
          b_re = 1'b1;
          b_raddr = nxt_p;
        end
      end
      S_UL_WFIX: begin
        b_we = 1'b1;
        b_waddr = p_q;
        b_wdata = b_next;
        status_d[cur_q] = ST_ALLOC;
        state_d = ret_q;
      end
      S_ARM_RD: begin
        a_re = 1'b1;
        a_raddr = cur_q;
        state_d = S_ARM_WR;
      end
      S_ARM_WR: begin
        a_we = 1'b1;
        a_waddr = cur_q;
        a_wdata = '{queue: a_rdata.queue, payload: a_rdata.payload, deadline: dd_q};
        status_d[cur_q] = ST_RUN;
        state_d = S_IN_START;
      end
      S_IN_START: begin
        p_d = head_q;
        first_d = 1'b1;
        a_re = 1'b1;
        a_raddr = head_q;
        state_d = S_IN_CHK;
      end
      S_IN_CHK: begin
        if (dd_q <= dl_p) begin
          b_we = 1'b1;
          if (first_q) begin
            b_waddr = cur_q;
            b_wdata = p_q;
            head_d = cur_q;
            earliest_d = dd_q;
            state_d = S_ACK;
          end else begin
            b_waddr = s_q;
            b_wdata = cur_q;
            state_d = S_IN_FIX;
          end
        end else begin
          s_d = p_q;
          b_re = 1'b1;
          b_raddr = p_q;
          state_d = S_IN_NX;
        end
      end
      S_IN_NX: begin
        p_d = nxt_p;
        first_d = 1'b0;
        a_re = 1'b1;
        a_raddr = nxt_p;
        state_d = S_IN_CHK;
      end
      S_IN_FIX: begin
        b_we = 1'b1;
        b_waddr = cur_q;
        b_wdata = p_q;
        state_d = S_ACK;
      end
      S_BD_RD: begin
        a_re = 1'b1;
        a_raddr = cur_q;
        state_d = S_BD_WR;
      end
      S_BD_WR: begin
        a_we = 1'b1;
        a_waddr = cur_q;
        a_wdata = '{queue: qid_q, payload: pay_q, deadline: a_rdata.deadline};
        acf_d[cur_q] = acin_q;
        state_d = S_ACK;
      end
      S_FREE_DONE: begin
        status_d[cur_q] = ST_FREE;
        state_d = S_ACK;
      end
      S_ACK: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_kind_d = KIND_NONE;
          out_queue_d = '0;
          out_pay_d = '0;
          out_idx_d = oidx_q;
          out_succ_d = succ_q;
          out_last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      head_q <= '0;
      earliest_q <= ALL_ONES;
      tick_q <= '0;
      task_q <= '0;
      cnt_q <= '0;
      ts_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < TIMER_COUNT; k++) begin
        status_q[k] <= (k == 0) ? ST_RUN : ST_FREE;
        acf_q[k] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      head_q <= head_d;
      earliest_q <= earliest_d;
      tick_q <= tick_d;
      task_q <= task_d;
      cnt_q <= cnt_d;
      ts_q <= ts_d;
      pend_v_q <= pend_v_d;
      out_valid_q <= out_valid_d;
      status_q <= status_d;
      acf_q <= acf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    cur_q <= cur_d;
    p_q <= p_d;
    s_q <= s_d;
    vld_q <= vld_d;
    first_q <= first_d;
    delay_q <= delay_d;
    dd_q <= dd_d;
    pay_q <= pay_d;
    pend_pay_q <= pend_pay_d;
    qid_q <= qid_d;
    pend_queue_q <= pend_queue_d;
    acin_q <= acin_d;
    scan_q <= scan_d;
    oidx_q <= oidx_d;
    succ_q <= succ_d;
    out_kind_q <= out_kind_d;
    out_queue_q <= out_queue_d;
    out_pay_q <= out_pay_d;
    out_idx_q <= out_idx_d;
    out_succ_q <= out_succ_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = out_kind_q;
  assign out_queue_o = out_queue_q;
  assign out_payload_o = out_pay_q;
  assign out_index_o = out_idx_q;
  assign success_o = out_succ_q;
  assign last_o = out_last_q;

  `SMTP_ASSERT_ALWAYS(a_sentinel_running, status_q[0] == ST_RUN, "sentinel left running state")
  `SMTP_ASSERT_IMPL(a_empty_list_earliest, head_q == '0, earliest_q == ALL_ONES, "empty list with finite earliest deadline")
  `SMTP_ASSERT_IMPL(a_head_running, state_q == S_IDLE, status_q[head_q] == ST_RUN, "list head not running while idle")
  `SMTP_ASSERT_IMPL(a_switch_last, out_valid_o && kind_o == KIND_SWITCH, last_o, "task switch beat not final")
  `SMTP_ASSERT_IMPL(a_no_stray_payload, out_valid_o && kind_o != KIND_EXPIRY, out_queue_o == 4'd0 && out_payload_o == 32'sd0, "non-expiry beat carries queue or payload")

endmodule

### verif/testbench.sv
// Self-checking testbench for the sorted timer pool: directed table, then random traffic.
`timescale 1ns / 1ps
module testbench;
  import smtp_pkg::*;

  localparam int NT = 32;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         queue;
    logic signed [31:0] payload;
    logic [4:0]         index;
    logic               success;
    logic               last;
  } result_t;

  typedef struct {
    logic [2:0]  act;
    logic [4:0]  idx;
    logic [31:0] dly;
    logic [31:0] pay;
    logic [3:0]  qid;
    logic        ac;
    bit          typed;
    logic [1:0]  kind;
    logic [4:0]  oidx;
    logic        ok;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [4:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         action_i = '0;
  logic [4:0]         timer_index_i = '0;
  logic [31:0]        delay_i = '0;
  logic signed [31:0] payload_i = '0;
  logic [3:0]         queue_id_i = '0;
  logic               auto_cancel_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [3:0]         out_queue_o;
  logic signed [31:0] out_payload_o;
  logic [4:0]         out_index_o;
  logic               success_o;
  logic               last_o;

  sorted_multi_timer_pool i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .action_i, .timer_index_i, .delay_i, .payload_i,
    .queue_id_i, .auto_cancel_i, .out_valid_o, .out_ready_i, .kind_o, .out_queue_o,
    .out_payload_o, .out_index_o, .success_o, .last_o
  );

  always #5 clk_i = ~clk_i;

  // pool mirror
  logic [1:0]  pool_st [NT];
  logic        pool_ac [NT];
  logic [3:0]  pool_q [NT];
  logic [31:0] pool_pay [NT];
  logic [31:0] pool_dl [NT];
  logic [4:0]  pool_lk [NT];
  bit          pool_bound [NT];
  logic [4:0]  list_head;
  logic [31:0] earliest;
  logic [31:0] ticks;
  logic [4:0]  task_idx;

  result_t pending_results[$];
  result_t step_results[$];
  int      errors = 0;

  function automatic result_t mk(logic [1:0] k, logic [3:0] q, logic [31:0] p,
                                 logic [4:0] ix, logic ok);
    result_t r;
    r.kind = k; r.queue = q; r.payload = p; r.index = ix; r.success = ok; r.last = 1'b0;
    return r;
  endfunction

  task automatic pool_reset();
    for (int i = 0; i < NT; i++) begin
      pool_st[i] = ST_FREE; pool_ac[i] = 0; pool_q[i] = 0; pool_pay[i] = 0;
      pool_dl[i] = ALL_ONES; pool_lk[i] = 0; pool_bound[i] = 0;
    end
    pool_st[0] = ST_RUN;
    list_head = 0; earliest = ALL_ONES; ticks = 0; task_idx = 0;
  endtask

  task automatic unlink_timer(input logic [4:0] i);
    logic [4:0] p;
    if (list_head == i) begin
      list_head = pool_lk[i];
      earliest = pool_dl[list_head];
    end else begin
      p = list_head;
      for (int s = 0; s < NT; s++) begin
        if (pool_lk[p] == i) begin
          pool_lk[p] = pool_lk[i];
          break;
        end
        if (p == 0) break;
        p = pool_lk[p];
      end
    end
    pool_st[i] = ST_ALLOC;
  endtask

  task automatic insert_timer(input logic [4:0] i);
    logic [31:0] d;
    logic [4:0]  s, t;
    d = pool_dl[i];
    pool_st[i] = ST_RUN;
    t = list_head;
    if (d <= pool_dl[t]) begin
      pool_lk[i] = t; list_head = i; earliest = d;
      return;
    end
    for (int n = 0; n < NT && t != 0; n++) begin
      s = t;
      t = pool_lk[t];
      if (d <= pool_dl[t]) begin
        pool_lk[s] = i; pool_lk[i] = t;
        return;
      end
    end
  endtask

  // Fill step_results with what the pool returns for one beat.
  task automatic advance_pool(input logic [2:0] act, input logic [4:0] idx,
                              input logic [31:0] dly, input logic [31:0] pay,
                              input logic [3:0] qid, input logic ac);
    bit         ok_idx, sw;
    logic [4:0] h;
    int         i;
    ok_idx = idx != 0;
    sw = 0;
    step_results.delete();
    case (act)
      ACT_TICK: begin
        ticks++;
        if (earliest <= ticks) begin
          h = list_head;
          for (int s = 0; s < NT; s++) begin
            if (h == 0 || pool_dl[h] > ticks) break;
            if (h != task_idx && step_results.size() >= MAX_RESULTS - 1) break;
            pool_st[h] = ST_ALLOC;
            if (h == task_idx) sw = 1;
            else step_results.push_back(mk(KIND_EXPIRY, pool_q[h], pool_pay[h], 0, 0));
            h = pool_lk[h];
          end
          list_head = h;
          earliest = pool_dl[h];
        end
        if (sw) step_results.push_back(mk(KIND_SWITCH, 0, 0, 0, 0));
        if (step_results.size() == 0) step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
      end
      ACT_ALLOC: begin
        for (i = 0; i < NT; i++) begin
          if (pool_st[i] == ST_FREE) begin
            pool_st[i] = ST_ALLOC; pool_ac[i] = 0;
            break;
          end
        end
        if (i < NT) step_results.push_back(mk(KIND_NONE, 0, 0, i[4:0], 1));
        else step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
      end
      ACT_FREE: begin
        if (ok_idx) begin
          if (pool_st[idx] == ST_RUN) unlink_timer(idx);
          pool_st[idx] = ST_FREE;
        end
        step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
      end
      ACT_BIND: begin
        if (ok_idx) begin
          pool_q[idx] = qid; pool_pay[idx] = pay; pool_ac[idx] = ac; pool_bound[idx] = 1;
        end
        step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
      end
      ACT_ARM: begin
        if (ok_idx && pool_st[idx] != ST_FREE) begin
          if (pool_st[idx] == ST_RUN) unlink_timer(idx);
          pool_dl[idx] = dly + ticks;
          insert_timer(idx);
        end
        step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
      end
      ACT_CANCEL: begin
        if (ok_idx && pool_st[idx] == ST_RUN) begin
          unlink_timer(idx);
          step_results.push_back(mk(KIND_NONE, 0, 0, 0, 1));
        end else begin
          step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
        end
      end
      ACT_CANCEL_ALL: begin
        for (int j = 1; j < NT; j++) begin
          if (pool_st[j] != ST_FREE && pool_ac[j] && pool_q[j] == qid) begin
            if (pool_st[j] == ST_RUN) unlink_timer(j[4:0]);
            pool_st[j] = ST_FREE;
          end
        end
        step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
      end
      default: step_results.push_back(mk(KIND_NONE, 0, 0, 0, 0));
    endcase
    step_results[step_results.size() - 1].last = 1'b1;
  endtask

  // Drive one beat; called at a rising edge, returns at a rising edge.
  task automatic send_beat(input row_t r);
    int gap;
    in_valid_i <= 1'b1;
    action_i <= r.act; timer_index_i <= r.idx; delay_i <= r.dly;
    payload_i <= r.pay; queue_id_i <= r.qid; auto_cancel_i <= r.ac;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_pool(r.act, r.idx, r.dly, r.pay, r.qid, r.ac);
    if (r.typed) begin
      if (step_results.size() != 1) begin
        $display("%0t: directed row %0d gave %0d results", $time, r.act, step_results.size());
        errors++;
      end
      pending_results.push_back(mk(r.kind, 0, 0, r.oidx, r.ok));
      pending_results[pending_results.size() - 1].last = 1'b1;
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      5, 6, 7, 8: gap = $urandom_range(1, 3);
      default: gap = $urandom_range(10, 60);
    endcase
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_task_index(input logic [4:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    task_idx = v;
  endtask

  function automatic row_t beat(logic [2:0] a, logic [4:0] ix, logic [31:0] d,
                                logic [31:0] p, logic [3:0] q, logic c);
    row_t r;
    r.act = a; r.idx = ix; r.dly = d; r.pay = p; r.qid = q; r.ac = c;
    r.typed = 0; r.kind = KIND_NONE; r.oidx = 0; r.ok = 0;
    return r;
  endfunction

  function automatic row_t typed_beat(row_t r, logic [1:0] k, logic [4:0] ix, logic ok);
    r.typed = 1; r.kind = k; r.oidx = ix; r.ok = ok;
    return r;
  endfunction

  function automatic logic [4:0] pick_timer();
    logic [4:0] live[$];
    for (int i = 1; i < NT; i++) if (pool_st[i] != ST_FREE) live.push_back(i[4:0]);
    if (live.size() != 0 && $urandom_range(0, 3) != 0)
      return live[$urandom_range(0, live.size() - 1)];
    return 5'($urandom_range(0, NT - 1));
  endfunction

  function automatic row_t random_beat();
    row_t       r;
    logic [2:0] a;
    logic [31:0] d;
    int         w;
    w = $urandom_range(0, 99);
    if (w < 30) a = ACT_TICK;
    else if (w < 42) a = ACT_ALLOC;
    else if (w < 50) a = ACT_FREE;
    else if (w < 65) a = ACT_BIND;
    else if (w < 85) a = ACT_ARM;
    else if (w < 93) a = ACT_CANCEL;
    else if (w < 97) a = ACT_CANCEL_ALL;
    else a = 3'd7;
    w = $urandom_range(0, 9);
    if (w < 7) d = $urandom_range(0, 6);
    else if (w < 9) d = $urandom_range(7, 64);
    else d = $urandom;
    r = beat(a, pick_timer(), d, $urandom,
             4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2)),
             1'($urandom_range(0, 1)));
    // never arm a timer whose queue and payload were never written
    if (r.act == ACT_ARM && !pool_bound[r.idx]) r.act = ACT_BIND;
    return r;
  endfunction

  row_t dir_rows[$];

  // out-side stall pattern
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: stall_left <= $urandom_range(1, 3);
        3: stall_left <= $urandom_range(10, 40);
        default: stall_left <= 0;
      endcase
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = kind_o; got.queue = out_queue_o; got.payload = out_payload_o;
      got.index = out_index_o; got.success = success_o; got.last = last_o;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
          $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
        if (got.queue !== want.queue)
          $display("%0t: queue expected %0d got %0d", $time, want.queue, got.queue);
        if (got.payload !== want.payload)
          $display("%0t: payload expected %h got %h", $time, want.payload, got.payload);
        if (got.index !== want.index)
          $display("%0t: index expected %0d got %0d", $time, want.index, got.index);
        if (got.success !== want.success)
          $display("%0t: success expected %0b got %0b", $time, want.success, got.success);
        if (got.last !== want.last)
          $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [4:0] cfg_vals [5];
    pool_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows.push_back(typed_beat(beat(ACT_TICK, 0, 0, 0, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_ALLOC, 0, 0, 0, 0, 0), KIND_NONE, 1, 1));
    dir_rows.push_back(typed_beat(beat(ACT_ALLOC, 0, 0, 0, 0, 0), KIND_NONE, 2, 1));
    dir_rows.push_back(typed_beat(beat(ACT_BIND, 1, 0, 32'h8000_0000, 15, 1), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_BIND, 2, 0, 32'h7fff_ffff, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_ARM, 1, 0, 0, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(beat(ACT_ARM, 2, ALL_ONES, 0, 0, 0));
    dir_rows.push_back(beat(ACT_TICK, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat(ACT_ARM, 2, 3, 0, 0, 0));
    dir_rows.push_back(beat(ACT_ARM, 2, 1, 0, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_CANCEL, 2, 0, 0, 0, 0), KIND_NONE, 0, 1));
    dir_rows.push_back(typed_beat(beat(ACT_CANCEL, 2, 0, 0, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_CANCEL, 0, 0, 0, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_FREE, 0, 0, 0, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_BIND, 0, 0, 5, 3, 1), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_ARM, 0, 0, 0, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(typed_beat(beat(3'd7, 31, ALL_ONES, ALL_ONES, 15, 1), KIND_NONE, 0, 0));
    dir_rows.push_back(beat(ACT_ARM, 1, 2, 0, 0, 0));
    dir_rows.push_back(typed_beat(beat(ACT_FREE, 1, 0, 0, 0, 0), KIND_NONE, 0, 0));
    dir_rows.push_back(beat(ACT_TICK, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat(ACT_ALLOC, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat(ACT_BIND, 1, 0, 32'h1234_5678, 15, 1));
    dir_rows.push_back(beat(ACT_ARM, 1, 5, 0, 0, 0));
    dir_rows.push_back(beat(ACT_CANCEL_ALL, 0, 0, 0, 15, 0));
    dir_rows.push_back(beat(ACT_TICK, 0, 0, 0, 0, 0));
    foreach (dir_rows[k]) send_beat(dir_rows[k]);

    // fill the pool, arm every timer with a delay of 1 or 2 and tick until all expire, the last entry as task timer
    write_task_index(5'd31);
    for (int i = 0; i < NT; i++) send_beat(beat(ACT_ALLOC, 0, 0, 0, 0, 0));
    for (int i = 1; i < NT; i++)
      send_beat(beat(ACT_BIND, i[4:0], 0, $urandom, 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1))));
    for (int i = 1; i < NT; i++)
      send_beat(beat(ACT_ARM, i[4:0], $urandom_range(1, 2), 0, 0, 0));
    repeat (3) send_beat(beat(ACT_TICK, 0, 0, 0, 0, 0));
    for (int i = 1; i < NT; i++) send_beat(beat(ACT_FREE, i[4:0], 0, 0, 0, 0));

    cfg_vals[0] = 5'd0;
    cfg_vals[1] = 5'($urandom_range(1, 30));
    cfg_vals[2] = 5'd31;
    cfg_vals[3] = 5'($urandom_range(1, 8));
    cfg_vals[4] = 5'($urandom_range(0, 31));
    foreach (cfg_vals[p]) begin
      write_task_index(cfg_vals[p]);
      for (int k = 0; k < 60; k++) send_beat(random_beat());
    end

    in_valid_i <= 1'b0;
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/smtp_pkg.sv
hdl/smtp_ram.sv
hdl/sorted_multi_timer_pool.sv
verif/testbench.sv
